@@ hdl/spq_pkg.sv @@
package spq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned PRIO_W       = 16;
    localparam int unsigned TAG_W        = 16;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned STATUS_W     = 2;

    typedef enum logic {
        CMD_OFFER = 1'b0,
        CMD_POLL  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic offer;
        logic poll;
    } t_cell_op;

    // what one cell shows its neighbours
    typedef struct packed {
        logic                     used;
        logic                     lower;   // empty or below the offered priority
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_cell_link;

endpackage

@@ hdl/spq_in_if.sv @@
interface spq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [spq_pkg::PRIO_W-1:0] priority_req;
    logic        [spq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, command, priority_req, tag, input ready);
    modport sink   (input valid, command, priority_req, tag, output ready);
endinterface

@@ hdl/spq_out_if.sv @@
interface spq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               result_valid;
    logic [spq_pkg::TAG_W-1:0]          result_tag;
    logic [spq_pkg::STATUS_W-1:0]       status;
    logic                               head_valid;
    logic [spq_pkg::TAG_W-1:0]          head_tag;
    logic [spq_pkg::COUNT_W-1:0]        count;

    modport source (output valid, result_valid, result_tag, status, head_valid, head_tag,
                    count, input ready);
    modport sink   (input valid, result_valid, result_tag, status, head_valid, head_tag,
                    count, output ready);
endinterface

@@ hdl/sorted_priority_queue.sv @@
// sorted priority queue built as a chain of cells, head in cell 0
// input channel i_in: command (offer or poll), priority_req and tag per item
// output channel o_out: one result item per input item, in order
//   result_valid/result_tag: tag stored by an offer or removed by a poll
//   status: done, poll on empty queue, or offer refused because full
//   head_valid/head_tag/count: queue contents after the item
// an offer is placed ahead of the first entry of strictly lower priority,
// so larger priorities leave first and equal priorities in arrival order
// every cell compares against the broadcast priority and either keeps its
// entry, takes the new one, or takes its neighbour's, all together in the same cycle
// the result item is registered and appears in the cycle after the input item is taken
// throughput: one item per cycle while o_out.ready is high, limited by the single output register
// a stalled receiver holds the result; a new item is taken in the cycle the
// waiting result leaves, otherwise i_in.ready stays low
// synchronous reset empties the queue at once (per-cell used bits cleared),
// no clearing pass; the output register is emptied too
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::t_cell_link w_link [CAPACITY];
    spq_pkg::t_cell_op   w_op;

    logic             w_accept;
    logic             w_is_offer;
    logic             w_full;
    logic             w_empty;
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic                          r_out_valid;
    logic                          r_res_valid, n_res_valid;
    logic [spq_pkg::TAG_W-1:0]     r_res_tag,   n_res_tag;
    spq_pkg::t_status              r_status,    n_status;
    logic                          r_head_valid, n_head_valid;
    logic [spq_pkg::TAG_W-1:0]     r_head_tag,   n_head_tag;
    logic [spq_pkg::COUNT_W-1:0]   r_count_out,  n_count_out;

    // take a new item whenever the output register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_offer = (spq_pkg::t_cmd'(i_in.command) == spq_pkg::CMD_OFFER);

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // refused offers and polls on empty leave the chain untouched
    assign w_op.offer = w_accept && w_is_offer && !w_full;
    assign w_op.poll  = w_accept && !w_is_offer && !w_empty;

    // the chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_cell_link w_prev;
        spq_pkg::t_cell_link w_next;

        if (g == 0) begin : g_first
            // nothing above the head can take the new entry
            assign w_prev = '{used: 1'b1, lower: 1'b0, prio: '0, tag: '0};
        end else begin : g_mid
            assign w_prev = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '{used: 1'b0, lower: 1'b1, prio: '0, tag: '0};
        end else begin : g_body
            assign w_next = w_link[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_new_prio (i_in.priority_req),
            .i_new_tag  (i_in.tag),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_link     (w_link[g])
        );
    end

    // count and the result item, head taken from the chain's next state
    always_comb begin
        n_count     = r_count;
        n_res_valid = 1'b0;
        n_res_tag   = '0;
        n_status    = spq_pkg::ST_DONE;
        n_head_tag  = w_link[0].tag;
        if (w_is_offer) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count     = r_count + CNT_W'(1);
                n_res_valid = 1'b1;
                n_res_tag   = i_in.tag;
                if (w_link[0].lower) begin
                    n_head_tag = i_in.tag;
                end
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_res_valid = 1'b1;
                n_res_tag   = w_link[0].tag;
                n_head_tag  = w_link[1].tag;
            end
        end
        n_head_valid = (n_count != '0);
        if (!n_head_valid) begin
            n_head_tag = '0;
        end
        n_count_out = spq_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_valid  <= n_res_valid;
            r_res_tag    <= n_res_tag;
            r_status     <= n_status;
            r_head_valid <= n_head_valid;
            r_head_tag   <= n_head_tag;
            r_count_out  <= n_count_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_valid = r_res_valid;
    assign o_out.result_tag   = r_res_tag;
    assign o_out.status       = r_status;
    assign o_out.head_valid   = r_head_valid;
    assign o_out.head_tag     = r_head_tag;
    assign o_out.count        = r_count_out;

    // used bits gathered for checking
    logic [CAPACITY-1:0] w_used_vec;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_used
        assign w_used_vec[g] = w_link[g].used;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_used_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_used_vec) == int'(r_count))
        else $error("used cells disagree with entry count");

    a_used_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_used_vec >> 1) & ~w_used_vec) == '0)
        else $error("gap in the used cells of the chain");

    a_offer_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.offer |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted offer did not add an entry");

    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_head_valid == (r_count != '0))
        else $error("head flag disagrees with entry count");

endmodule

@@ hdl/spq_cell.sv @@
module spq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cell_op                 i_op,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_new_prio,
    input  logic        [spq_pkg::TAG_W-1:0]  i_new_tag,
    input  spq_pkg::t_cell_link               i_prev,
    input  spq_pkg::t_cell_link               i_next,
    output spq_pkg::t_cell_link               o_link
);

    logic                              r_used, n_used;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic        [spq_pkg::TAG_W-1:0]  r_tag,  n_tag;
    logic                              w_lower;

    // strictly lower priority, so equal priorities keep arrival order
    assign w_lower = !r_used || (r_prio < i_new_prio);

    assign o_link = '{used: r_used, lower: w_lower, prio: r_prio, tag: r_tag};

    always_comb begin
        n_used = r_used;
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_op.offer) begin
            if (i_prev.lower) begin
                // insertion point lies above: move down one place
                n_used = i_prev.used;
                n_prio = i_prev.prio;
                n_tag  = i_prev.tag;
            end else if (w_lower) begin
                n_used = 1'b1;
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end
        end else if (i_op.poll) begin
            n_used = i_next.used;
            n_prio = i_next.prio;
            n_tag  = i_next.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

endmodule
